// File: design/ssst_pkg.sv
// Shared widths, reset values and defaults for the sample set statistics block.
package ssst_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COUNT_W       = 7;
    localparam int MEAN_W        = 24;
    localparam int STD_W         = 24;
    localparam int MAX_COUNT_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// File: design/ssst_in_if.sv
// Input channel: one sample word with its end-of-set flag.
interface ssst_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [ssst_pkg::SAMPLE_W-1:0]   sample;
    logic                                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);

endinterface

// File: design/ssst_out_if.sv
// Output channel: one statistics word per finished set.
interface ssst_out_if;

    logic                                   valid;
    logic                                   ready;
    logic        [ssst_pkg::COUNT_W-1:0]    count;
    logic signed [ssst_pkg::MEAN_W-1:0]     mean_q8;
    logic signed [ssst_pkg::SAMPLE_W-1:0]   minimum;
    logic signed [ssst_pkg::SAMPLE_W-1:0]   maximum;
    logic        [ssst_pkg::STD_W-1:0]      std_dev_q8;
    logic                                   too_many;

    modport source (output valid, output count, output mean_q8, output minimum,
                    output maximum, output std_dev_q8, output too_many, input ready);
    modport sink   (input valid, input count, input mean_q8, input minimum,
                    input maximum, input std_dev_q8, input too_many, output ready);

endinterface

// File: design/ssst_front.sv
// Front end: accumulates count, sum, sum of squares, minimum and maximum per sample.
module ssst_front #(
    parameter int MAX_COUNT = ssst_pkg::MAX_COUNT_DEF,
    parameter int CNT_W     = $clog2(MAX_COUNT + 1),
    parameter int SUM_W     = CNT_W + 16,
    parameter int SQ_W      = CNT_W + 30,
    parameter int REC_W     = CNT_W + SUM_W + SQ_W + 2 * ssst_pkg::SAMPLE_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    ssst_in_if.sink          in_ch,
    input  logic             q_full,
    output logic             q_push,
    output logic [REC_W-1:0] q_data
);

    logic        [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]              sum_reg, sum_next;
    logic        [SQ_W-1:0]               sq_reg, sq_next;
    logic signed [ssst_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic signed [ssst_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic                                 ovf_reg, ovf_next;

    logic                                 take;
    logic                                 room;
    logic signed [31:0]                   square;

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && in_ch.ready;
    assign room        = cnt_reg < CNT_W'(MAX_COUNT);
    assign square      = in_ch.sample * in_ch.sample;

    // Updated totals including the current word; the record for the set is taken from these.
    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        min_next = min_reg;
        max_next = max_reg;
        ovf_next = ovf_reg;
        if (room)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            sum_next = sum_reg + SUM_W'(in_ch.sample);
            sq_next  = sq_reg + SQ_W'($unsigned(square));
            if (in_ch.sample < min_reg)
            begin
                min_next = in_ch.sample;
            end
            if (in_ch.sample > max_reg)
            begin
                max_next = in_ch.sample;
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign q_push = take && in_ch.last;
    assign q_data = {cnt_next, sum_next, sq_next, min_next, max_next, ovf_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= ssst_pkg::SAMPLE_MAX;
            max_reg <= ssst_pkg::SAMPLE_MIN;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (in_ch.last)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
                min_reg <= ssst_pkg::SAMPLE_MAX;
                max_reg <= ssst_pkg::SAMPLE_MIN;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
                min_reg <= min_next;
                max_reg <= max_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

// File: design/ssst_fifo.sv
// Short queue of finished set records between the front and back ends.
module ssst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ssst_pkg::QUEUE_DEPTH,
    parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = fill_reg == FILL_W'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/ssst_back.sv
// Back end: shift-add products, restoring divides and square root for one set record.
module ssst_back #(
    parameter int MAX_COUNT = ssst_pkg::MAX_COUNT_DEF,
    parameter int CNT_W     = $clog2(MAX_COUNT + 1),
    parameter int SUM_W     = CNT_W + 16,
    parameter int SQ_W      = CNT_W + 30,
    parameter int REC_W     = CNT_W + SUM_W + SQ_W + 2 * ssst_pkg::SAMPLE_W + 1,
    parameter int MAG_W     = SUM_W - 1,
    parameter int D_W       = 2 * CNT_W + 30,
    parameter int NN_W      = 2 * CNT_W,
    parameter int DVD_W     = D_W + 16,
    parameter int RT_W      = (DVD_W + 1) / 2,
    parameter int CTR_W     = $clog2(DVD_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  logic [REC_W-1:0] q_data,
    output logic             q_pop,
    ssst_out_if.source       out_ch
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MULA = 7'b0000010,
        S_MULB = 7'b0000100,
        S_DIVS = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIVM = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CTR_W-1:0] ctr_reg, ctr_next;

    logic        [CNT_W-1:0]              n_reg, n_next;
    logic                                 neg_reg, neg_next;
    logic        [MAG_W-1:0]              mag_reg, mag_next;
    logic signed [ssst_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic signed [ssst_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic                                 ovf_reg, ovf_next;
    logic        [D_W-1:0]                acc_reg, acc_next;
    logic        [D_W-1:0]                mcand_reg, mcand_next;
    logic        [MAG_W-1:0]              mplier_reg, mplier_next;
    logic        [NN_W-1:0]               nn_reg, nn_next;
    logic        [NN_W-1:0]               dvs_reg, dvs_next;
    logic        [NN_W-1:0]               rem_reg, rem_next;
    logic        [DVD_W-1:0]              quo_reg, quo_next;
    logic        [2*RT_W-1:0]             rad_reg, rad_next;
    logic        [RT_W:0]                 srem_reg, srem_next;
    logic        [RT_W-1:0]               root_reg, root_next;
    logic        [ssst_pkg::STD_W-1:0]    std_reg, std_next;
    logic signed [ssst_pkg::MEAN_W-1:0]   mean_reg, mean_next;

    // Fields of the queued record.
    logic        [CNT_W-1:0]              rec_cnt;
    logic signed [SUM_W-1:0]              rec_sum;
    logic        [SQ_W-1:0]               rec_sq;
    logic signed [ssst_pkg::SAMPLE_W-1:0] rec_min;
    logic signed [ssst_pkg::SAMPLE_W-1:0] rec_max;
    logic                                 rec_ovf;

    // One step of the shared restoring divider and of the root digit recurrence.
    logic [NN_W:0]   div_sh;
    logic            div_ge;
    logic [NN_W-1:0] div_rem;
    logic [DVD_W-1:0] div_quo;
    logic [RT_W+2:0] sq_sh;
    logic [RT_W+2:0] sq_trial;
    logic            sq_ge;
    logic            last_step;

    assign {rec_cnt, rec_sum, rec_sq, rec_min, rec_max, rec_ovf} = q_data;

    assign div_sh  = {rem_reg, quo_reg[DVD_W-1]};
    assign div_ge  = div_sh >= {1'b0, dvs_reg};
    assign div_rem = div_ge ? NN_W'(div_sh - {1'b0, dvs_reg}) : NN_W'(div_sh);
    assign div_quo = {quo_reg[DVD_W-2:0], div_ge};

    assign sq_sh    = {srem_reg, rad_reg[2*RT_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign last_step = ctr_reg == CTR_W'(1);

    assign q_pop = (state_reg == S_IDLE) && q_not_empty;

    always_comb
    begin
        state_next  = state_reg;
        ctr_next    = ctr_reg;
        n_next      = n_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        nn_next     = nn_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        rad_next    = rad_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        std_next    = std_reg;
        mean_next   = mean_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    n_next      = rec_cnt;
                    neg_next    = rec_sum < 0;
                    mag_next    = (rec_sum < 0) ? MAG_W'(-rec_sum) : MAG_W'(rec_sum);
                    min_next    = rec_min;
                    max_next    = rec_max;
                    ovf_next    = rec_ovf;
                    nn_next     = NN_W'(rec_cnt) * NN_W'(rec_cnt);
                    acc_next    = '0;
                    mcand_next  = D_W'(rec_sq);
                    mplier_next = MAG_W'(rec_cnt);
                    ctr_next    = CTR_W'(CNT_W);
                    state_next  = S_MULA;
                end
            end
            S_MULA:
            begin
                // n * sum of squares, one multiplier bit a cycle.
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                ctr_next    = ctr_reg - CTR_W'(1);
                if (last_step)
                begin
                    mcand_next  = D_W'(mag_reg);
                    mplier_next = mag_reg;
                    ctr_next    = CTR_W'(MAG_W);
                    state_next  = S_MULB;
                end
            end
            S_MULB:
            begin
                // Subtract sum squared; the difference is never negative.
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg - mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                ctr_next    = ctr_reg - CTR_W'(1);
                if (last_step)
                begin
                    quo_next   = {acc_next, 16'b0};
                    rem_next   = '0;
                    dvs_next   = nn_reg;
                    ctr_next   = CTR_W'(DVD_W);
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                ctr_next = ctr_reg - CTR_W'(1);
                if (last_step)
                begin
                    rad_next   = (2 * RT_W)'(div_quo);
                    srem_next  = '0;
                    root_next  = '0;
                    ctr_next   = CTR_W'(RT_W);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                srem_next = sq_ge ? (RT_W + 1)'(sq_sh - sq_trial) : (RT_W + 1)'(sq_sh);
                root_next = (RT_W)'({root_reg, sq_ge});
                rad_next  = rad_reg << 2;
                ctr_next  = ctr_reg - CTR_W'(1);
                if (last_step)
                begin
                    std_next   = ssst_pkg::STD_W'(root_next);
                    quo_next   = DVD_W'({mag_reg, 8'b0});
                    rem_next   = '0;
                    dvs_next   = NN_W'(n_reg);
                    ctr_next   = CTR_W'(DVD_W);
                    state_next = S_DIVM;
                end
            end
            S_DIVM:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                ctr_next = ctr_reg - CTR_W'(1);
                if (last_step)
                begin
                    // Dividing the magnitude and restoring the sign truncates toward zero.
                    mean_next  = neg_reg ? ssst_pkg::MEAN_W'(-div_quo)
                                         : ssst_pkg::MEAN_W'(div_quo);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        ovf_reg    <= ovf_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        nn_reg     <= nn_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        std_reg    <= std_next;
        mean_reg   <= mean_next;
    end

    assign out_ch.valid      = state_reg == S_OUT;
    assign out_ch.count      = ssst_pkg::COUNT_W'(n_reg);
    assign out_ch.mean_q8    = mean_reg;
    assign out_ch.minimum    = min_reg;
    assign out_ch.maximum    = max_reg;
    assign out_ch.std_dev_q8 = std_reg;
    assign out_ch.too_many   = ovf_reg;

endmodule

// File: design/sample_set_statistics.sv
// Top level of the sample set statistics block: front end, record queue and back end.
//
//  channel   dir  payload                                               word
//  samples   in   sample, last                                          one sample
//  results   out  count, mean_q8, minimum, maximum, std_dev_q8, too_many one set summary
//
// The front end takes one sample word per cycle while the record queue has room.
// Each finished set passes through the back end's serial multiplier, divider and square root,
// then the divider again for the mean, and waits at the output until it is taken.
// The queue holds two finished sets, so samples stall only when both are still pending.
// Reset clears the accumulators and the queue and returns the back end to idle.
module sample_set_statistics #(
    parameter int MAX_COUNT = ssst_pkg::MAX_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ssst_in_if.sink     samples,
    ssst_out_if.source  results
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int SUM_W = CNT_W + 16;
    localparam int SQ_W  = CNT_W + 30;
    localparam int REC_W = CNT_W + SUM_W + SQ_W + 2 * ssst_pkg::SAMPLE_W + 1;

    logic             q_push;
    logic             q_full;
    logic [REC_W-1:0] q_in_data;
    logic             q_pop;
    logic             q_not_empty;
    logic [REC_W-1:0] q_out_data;

    ssst_front #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .SQ_W      (SQ_W),
        .REC_W     (REC_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (samples),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in_data)
    );

    ssst_fifo #(
        .WIDTH (REC_W),
        .DEPTH (ssst_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out_data)
    );

    ssst_back #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .SQ_W      (SQ_W),
        .REC_W     (REC_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_out_data),
        .q_pop       (q_pop),
        .out_ch      (results)
    );

endmodule
